// ----- rtl/ftk_pkg.sv -----
// Types, register indexes and constants shared by the top-k selector files.
package ftk_pkg;

  localparam int HEAP_DEPTH_DEF = 16;
  localparam int KEEP_W         = 5;
  localparam int FILL_W         = 5;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic [31:0] EMPTY_ID = 32'hFFFF_FFFF;

  // command codes
  localparam logic CMD_OFFER = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MODE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_VALUE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RERANK_ENABLE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_RADIUS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SLACK     = 3'd6;

  localparam logic [KEEP_W-1:0] KEEP_COUNT_RST = 5'd10;

  typedef struct packed {
    logic               command;
    logic signed [31:0] cand_distance;
    logic               cand_finite;
    logic        [31:0] cand_id;
    logic               attr_pass;
    logic               id_pass;
  } ftk_cmd_t;

  typedef struct packed {
    logic               accepted;
    logic               evicted;
    logic               entry_valid;
    logic        [31:0] result_id;
    logic signed [31:0] result_distance;
    logic [FILL_W-1:0]  fill_count;
    logic               last;
  } ftk_res_t;

  typedef struct packed {
    logic [KEEP_W-1:0]  keep_count;
    logic               range_mode;
    logic               threshold_enable;
    logic signed [31:0] threshold_value;
    logic               rerank_enable;
    logic signed [31:0] search_radius;
    logic        [15:0] radius_slack;
  } ftk_cfg_t;

  // filter outcome for one candidate
  typedef struct packed {
    logic pass;      // filters, empty-slot and threshold checks all passed
    logic in_range;  // finite and within radius plus slack
  } ftk_verdict_t;

  typedef struct packed {
    logic signed [31:0] distance;
    logic        [31:0] id;
  } ftk_entry_t;

endpackage

// ----- rtl/ftk_gate.sv -----
// Candidate filter: pass bits, empty-slot id, threshold and radius checks.
module ftk_gate (
  input  ftk_pkg::ftk_cmd_t     item_i,
  input  ftk_pkg::ftk_cfg_t     cfg_i,
  output ftk_pkg::ftk_verdict_t verdict_o
);
  import ftk_pkg::*;

  logic signed [33:0] dist_x;
  logic signed [33:0] lim_x;
  logic               over_thr;
  logic               thr_fail;

  always_comb begin
    dist_x   = {{2{item_i.cand_distance[31]}}, item_i.cand_distance};
    // radius plus slack, two guard bits so the sum never wraps
    lim_x    = {{2{cfg_i.search_radius[31]}}, cfg_i.search_radius}
               + {18'd0, cfg_i.radius_slack};
    over_thr = $signed(item_i.cand_distance) > $signed(cfg_i.threshold_value);
    thr_fail = !cfg_i.range_mode && cfg_i.threshold_enable &&
               (!item_i.cand_finite || (!cfg_i.rerank_enable && over_thr));

    verdict_o.pass     = item_i.attr_pass && item_i.id_pass &&
                         (item_i.cand_id != EMPTY_ID) && !thr_fail;
    verdict_o.in_range = item_i.cand_finite && (dist_x <= lim_x);
  end

endmodule

// ----- rtl/filtered_topk_selector_top.sv -----
// Top level of the filtered top-k selector: kept-entry memory and its sequencer.
//
//  channel   | ports                               | transfer when
//  ----------+-------------------------------------+---------------------------
//  command   | start, busy, item_i                 | start high, busy low
//  result    | res_valid_o, res_o                  | every cycle res_valid_o is high
//  config    | cfg_we_i, cfg_idx_i, cfg_wdata_i    | every cycle cfg_we_i is high
//
// Flow: a candidate that is filtered out, or that lands while fewer than K
// entries are held, gives its result on the next cycle with busy staying low.
// Comparing against a full store takes a scan of the K held entries through the
// memory read port. Each eviction or drained entry costs one scan of the held
// entries, a pick of the maximum and, when that was not the last entry, a move
// of the last entry into its slot; the single read port sets the pace.
// Reset (rst_ni low, asynchronous) restores register defaults and empties the
// store; memory contents are not cleared, entries past the count are never read.
// Results leave through a register and cannot be stalled; busy holds off start.
module filtered_topk_selector_top #(
  parameter int HEAP_DEPTH = ftk_pkg::HEAP_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  ftk_pkg::ftk_cmd_t                   item_i,
  output logic                                res_valid_o,
  output ftk_pkg::ftk_res_t                   res_o,
  input  logic                                cfg_we_i,
  input  logic [ftk_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ftk_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import ftk_pkg::*;

  // one spare entry: an insertion may overfill the store before trimming
  localparam int MEM_D = HEAP_DEPTH + 1;
  localparam int AW    = $clog2(MEM_D);
  localparam int CW    = $clog2(HEAP_DEPTH + 2);
  localparam int KW    = (CW > KEEP_W) ? CW : KEEP_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;  // stream held entries, track maximum
  localparam logic [1:0] ST_PICK = 2'd2;  // compare or evict the maximum
  localparam logic [1:0] ST_MVWR = 2'd3;  // last entry fills the hole

  localparam logic [1:0] PH_CMP   = 2'd0;
  localparam logic [1:0] PH_EVICT = 2'd1;
  localparam logic [1:0] PH_DRAIN = 2'd2;

  ftk_cfg_t     cfg_q;
  logic [1:0]   state_q, state_d;
  logic [1:0]   phase_q, phase_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] scan_idx_q, scan_idx_d;
  logic          rpend_q, rpend_d;
  logic [AW-1:0] ridx_q, ridx_d;
  logic          acc_q, acc_d;
  ftk_cmd_t      item_q, item_d;
  ftk_verdict_t  verd_q, verd_d;
  ftk_verdict_t  verd_in;
  ftk_entry_t    max_q, max_d;
  logic [AW-1:0] max_idx_q, max_idx_d;
  ftk_res_t      res_q, res_d;
  logic          res_vld_q, res_vld_d;

  // kept-entry memory, one write and one registered read port
  ftk_entry_t    mem_q [MEM_D];
  ftk_entry_t    rd_data_q;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  ftk_entry_t    wr_data;

  logic [KW-1:0] kc_w;
  logic [CW-1:0] eff_k;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_new;
  logic [CW-1:0] target;
  logic          ins;
  logic          below;
  logic          better;
  logic          drain;

  function automatic ftk_res_t mk_res(logic acc, logic ev, logic vld, logic [31:0] id,
                                      logic signed [31:0] res_dist, logic [CW-1:0] fill,
                                      logic lst);
    ftk_res_t r;
    r.accepted        = acc;
    r.evicted         = ev;
    r.entry_valid     = vld;
    r.result_id       = id;
    r.result_distance = res_dist;
    r.fill_count      = FILL_W'(fill);
    r.last            = lst;
    return r;
  endfunction

  ftk_gate u_gate (
    .item_i    (item_i),
    .cfg_i     (cfg_q),
    .verdict_o (verd_in)
  );

  // K clamped to 1..HEAP_DEPTH
  always_comb begin
    kc_w = KW'(cfg_q.keep_count);
    if (kc_w == '0) begin
      eff_k = CW'(1);
    end else if (kc_w > KW'(HEAP_DEPTH)) begin
      eff_k = CW'(HEAP_DEPTH);
    end else begin
      eff_k = CW'(kc_w);
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;
  assign cnt_m1      = cnt_q - CW'(1);
  assign drain       = (phase_q == PH_DRAIN);
  assign target      = drain ? '0 : eff_k;

  // (distance, id) ordering: larger distance, then larger id, is the maximum
  assign better = ($signed(rd_data_q.distance) > $signed(max_q.distance)) ||
                  ((rd_data_q.distance == max_q.distance) && (rd_data_q.id > max_q.id));
  assign below  = item_q.cand_finite &&
                  ($signed(item_q.cand_distance) < $signed(max_q.distance));

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    scan_idx_d = scan_idx_q;
    rpend_d    = 1'b0;
    ridx_d     = scan_idx_q[AW-1:0];
    acc_d      = acc_q;
    item_d     = item_q;
    verd_d     = verd_q;
    max_d      = max_q;
    max_idx_d  = max_idx_q;
    res_d      = res_q;
    res_vld_d  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = scan_idx_q[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = cnt_q[AW-1:0];
    wr_data    = '{distance: item_q.cand_distance, id: item_q.cand_id};
    ins        = 1'b0;
    cnt_new    = cnt_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          item_d     = item_i;
          verd_d     = verd_in;
          acc_d      = 1'b0;
          scan_idx_d = '0;
          if (item_i.command == CMD_DRAIN) begin
            phase_d = PH_DRAIN;
            if (cnt_q == '0) begin
              res_vld_d = 1'b1;
              res_d     = mk_res(1'b0, 1'b0, 1'b0, '0, '0, '0, 1'b1);
            end else begin
              state_d = ST_SCAN;
            end
          end else if (!verd_in.pass) begin
            res_vld_d = 1'b1;
            res_d     = mk_res(1'b0, 1'b0, 1'b0, '0, '0, cnt_q, 1'b1);
          end else if (cnt_q == eff_k) begin
            phase_d = PH_CMP;
            state_d = ST_SCAN;
          end else begin
            // not full, or above K after K was lowered: no comparison
            ins     = !cfg_q.range_mode || verd_in.in_range;
            wr_en   = ins;
            wr_data = '{distance: item_i.cand_distance, id: item_i.cand_id};
            cnt_new = cnt_q + CW'(ins);
            cnt_d   = cnt_new;
            if (cnt_new > eff_k) begin
              acc_d   = ins;
              phase_d = PH_EVICT;
              state_d = ST_SCAN;
            end else begin
              res_vld_d = 1'b1;
              res_d     = mk_res(ins, 1'b0, 1'b0, '0, '0, cnt_new, 1'b1);
            end
          end
        end
      end

      ST_SCAN: begin
        if (scan_idx_q < cnt_q) begin
          rd_en      = 1'b1;
          rpend_d    = 1'b1;
          scan_idx_d = scan_idx_q + CW'(1);
        end
        if (rpend_q) begin
          if ((ridx_q == '0) || better) begin
            max_d     = rd_data_q;
            max_idx_d = ridx_q;
          end
          if (ridx_q == cnt_m1[AW-1:0]) begin
            state_d = ST_PICK;
          end
        end
      end

      ST_PICK: begin
        if (phase_q == PH_CMP) begin
          ins = cfg_q.range_mode ? (verd_q.in_range && below) : below;
          if (ins) begin
            wr_en      = 1'b1;
            cnt_d      = cnt_q + CW'(1);
            acc_d      = 1'b1;
            phase_d    = PH_EVICT;
            scan_idx_d = '0;
            state_d    = ST_SCAN;
          end else begin
            res_vld_d = 1'b1;
            res_d     = mk_res(1'b0, 1'b0, 1'b0, '0, '0, cnt_q, 1'b1);
            state_d   = ST_IDLE;
          end
        end else begin
          res_vld_d  = 1'b1;
          res_d      = mk_res(acc_q, !drain, 1'b1, max_q.id, max_q.distance, target,
                              cnt_m1 == target);
          cnt_d      = cnt_m1;
          scan_idx_d = '0;
          if (max_idx_q != cnt_m1[AW-1:0]) begin
            // fetch the last entry to fill the hole
            rd_en   = 1'b1;
            rd_addr = cnt_m1[AW-1:0];
            state_d = ST_MVWR;
          end else if (cnt_m1 > target) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_MVWR: begin
        wr_en      = 1'b1;
        wr_addr    = max_idx_q;
        wr_data    = rd_data_q;
        scan_idx_d = '0;
        state_d    = (cnt_q > target) ? ST_SCAN : ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_CMP;
      cnt_q     <= '0;
      rpend_q   <= 1'b0;
      res_vld_q <= 1'b0;
      cfg_q     <= '{keep_count: KEEP_COUNT_RST, default: '0};
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      rpend_q   <= rpend_d;
      res_vld_q <= res_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_KEEP_COUNT:       cfg_q.keep_count       <= cfg_wdata_i[KEEP_W-1:0];
          CFG_RANGE_MODE:       cfg_q.range_mode       <= cfg_wdata_i[0];
          CFG_THRESHOLD_ENABLE: cfg_q.threshold_enable <= cfg_wdata_i[0];
          CFG_THRESHOLD_VALUE:  cfg_q.threshold_value  <= cfg_wdata_i[31:0];
          CFG_RERANK_ENABLE:    cfg_q.rerank_enable    <= cfg_wdata_i[0];
          CFG_SEARCH_RADIUS:    cfg_q.search_radius    <= cfg_wdata_i[31:0];
          CFG_RADIUS_SLACK:     cfg_q.radius_slack     <= cfg_wdata_i[15:0];
          default: ;  // unmapped index, write dropped
        endcase
      end
    end
  end

  // payload and scan registers, no reset needed
  always_ff @(posedge clk_i) begin
    scan_idx_q <= scan_idx_d;
    ridx_q     <= ridx_d;
    acc_q      <= acc_d;
    item_q     <= item_d;
    verd_q     <= verd_d;
    max_q      <= max_d;
    max_idx_q  <= max_idx_d;
    res_q      <= res_d;
  end

endmodule

// ----- rtl/ftk_checker.sv -----
// Port-level checks for the top-k selector, bound to its top level.
module ftk_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              res_valid_o,
  input ftk_pkg::ftk_res_t res_o
);
  import ftk_pkg::*;

  // an eviction always carries an entry
  a_evict_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.evicted |-> res_o.entry_valid)
    else $error("evicted result without an entry");

  // a result without an entry is the only, hence last, result of its item
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.entry_valid |-> res_o.last)
    else $error("entry-less result not marked last");

  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.entry_valid |->
      (res_o.result_id == '0) && (res_o.result_distance == '0))
    else $error("entry-less result carries non-zero payload");

  // an accepted command either answers at once or keeps the block busy
  a_start_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || res_valid_o)
    else $error("accepted command neither answered nor busy");

  // more results pending means the block is still working
  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy)
    else $error("non-final result while idle");

endmodule

bind filtered_topk_selector_top ftk_checker u_ftk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

// ----- tb/sv/filtered_topk_selector_top_test.sv -----
// Self-checking testbench for the filtered top-k selector: directed table, then random searches.
`timescale 1ns / 1ps

module filtered_topk_selector_top_test;
  import ftk_pkg::*;

  localparam int TOPK_DEPTH     = HEAP_DEPTH_DEF;
  localparam int RAND_ITEMS     = 450;
  localparam int PHASE_ITEMS    = 40;
  // Cycles with neither a command nor a result transfer before the run is abandoned.
  // Slowest legitimate gap is an offer that evicts from a full store (a compare
  // scan, then an evict scan) or a long idle stretch of the sender, so this is many times over.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 64;
  localparam int MAX_REPORTS    = 10;

  // Index past the last register: writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  // Directed table rows: a register write, an item checked by the predictor, or an
  // item whose single result is typed in by hand.
  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_ITEM,
    ROW_KNOWN
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    ftk_cmd_t              item;
    ftk_res_t              want;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and the block's ports; every input is known from time zero.
  // ---------------------------------------------------------------------------
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  ftk_cmd_t              item_i      = '0;
  logic                  res_valid_o;
  ftk_res_t              res_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  filtered_topk_selector_top #(
    .HEAP_DEPTH(TOPK_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the registers and of the kept set.
  // One spare slot holds the candidate inserted while the store is already full.
  // ---------------------------------------------------------------------------
  ftk_cfg_t           cfg_mirror;
  logic signed [31:0] kept_dist [0:TOPK_DEPTH];
  logic        [31:0] kept_id   [0:TOPK_DEPTH];
  int unsigned        kept_n;

  ftk_res_t step_res[$];     // results of the item just predicted
  ftk_res_t pending_res[$];  // results still owed by the block, oldest first
  dir_row_t dir_tab[$];

  bit                 drv_start = 1'b0;  // mirror of start as last driven
  int                 idle_pct  = 0;     // sender idle chance per cycle, in percent
  logic signed [31:0] aim;               // distance the random candidates cluster around
  ftk_res_t           want_res;
  int                 stall_cycles = 0;
  int n_errors = 0, n_items = 0, n_drains = 0, n_results = 0, n_evictions = 0;
  int n_settings = 0, n_rand = 0, ph = 0, ph_items = 0, n_off = 0;

  // K as the block uses it: 0 counts as 1, above the depth counts as the depth.
  function automatic int unsigned eff_keep();
    if (cfg_mirror.keep_count == 0) return 1;
    if (cfg_mirror.keep_count > TOPK_DEPTH) return TOPK_DEPTH;
    return cfg_mirror.keep_count;
  endfunction

  // Slot of the worst kept entry; ties on distance go to the larger id.
  function automatic int unsigned worst_slot();
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < kept_n; i++) begin
      if (kept_dist[i] > kept_dist[best] ||
          (kept_dist[i] == kept_dist[best] && kept_id[i] > kept_id[best]))
        best = i;
    end
    return best;
  endfunction

  // Remove a slot by moving the last held entry into it.
  task automatic drop_slot(input int unsigned slot);
    kept_n--;
    kept_dist[slot] = kept_dist[kept_n];
    kept_id[slot]   = kept_id[kept_n];
  endtask

  task automatic mirror_reset();
    cfg_mirror            = '0;
    cfg_mirror.keep_count = KEEP_COUNT_RST;
    kept_n                = 0;
  endtask

  // Works out the results of one command and moves the kept set along.
  task automatic topk_predict(input ftk_cmd_t c);
    int unsigned k;
    int unsigned slot;
    logic        pass;
    logic        ins;
    logic        below;
    logic        acc;
    longint      lim;
    ftk_res_t    r;
    step_res.delete();
    k = eff_keep();
    if (c.command == CMD_DRAIN) begin
      // worst first, store left empty
      while (kept_n > 0) begin
        slot              = worst_slot();
        r                 = '0;
        r.entry_valid     = 1'b1;
        r.result_id       = kept_id[slot];
        r.result_distance = kept_dist[slot];
        step_res.push_back(r);
        drop_slot(slot);
      end
      if (step_res.size() == 0) begin
        r = '0;
        step_res.push_back(r);
      end
    end else begin
      acc  = 1'b0;
      pass = c.attr_pass && c.id_pass && (c.cand_id != EMPTY_ID);
      if (pass && !cfg_mirror.range_mode && cfg_mirror.threshold_enable &&
          (!c.cand_finite ||
           (!cfg_mirror.rerank_enable && c.cand_distance > cfg_mirror.threshold_value)))
        pass = 1'b0;
      if (pass) begin
        // only a store holding exactly K compares against its worst entry
        if (kept_n == k)
          below = c.cand_finite && (c.cand_distance < kept_dist[worst_slot()]);
        else
          below = 1'b1;
        if (cfg_mirror.range_mode) begin
          lim = longint'(cfg_mirror.search_radius) + longint'(cfg_mirror.radius_slack);
          ins = c.cand_finite && (longint'(c.cand_distance) <= lim) && below;
        end else begin
          ins = below;
        end
        if (ins) begin
          kept_dist[kept_n] = c.cand_distance;
          kept_id[kept_n]   = c.cand_id;
          kept_n++;
          acc = 1'b1;
        end
        // trim back to K; after K was lowered this may take several evictions
        while (kept_n > k) begin
          slot              = worst_slot();
          r                 = '0;
          r.accepted        = acc;
          r.evicted         = 1'b1;
          r.entry_valid     = 1'b1;
          r.result_id       = kept_id[slot];
          r.result_distance = kept_dist[slot];
          step_res.push_back(r);
          drop_slot(slot);
        end
      end
      if (step_res.size() == 0) begin
        r          = '0;
        r.accepted = acc;
        step_res.push_back(r);
      end
      foreach (step_res[i]) step_res[i].fill_count = FILL_W'(kept_n);
    end
    step_res[step_res.size()-1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic ftk_cmd_t offer(input logic [31:0] distance, input logic [31:0] id,
                                     input int fin, input int ap, input int ip);
    ftk_cmd_t c;
    c.command       = CMD_OFFER;
    c.cand_distance = distance;
    c.cand_finite   = 1'(fin);
    c.cand_id       = id;
    c.attr_pass     = 1'(ap);
    c.id_pass       = 1'(ip);
    return c;
  endfunction

  // Drain ignores the payload, so it carries random bits.
  function automatic ftk_cmd_t drain_cmd();
    ftk_cmd_t c;
    c = offer($urandom, $urandom, 1'($urandom), 1'($urandom), 1'($urandom));
    c.command = CMD_DRAIN;
    return c;
  endfunction

  function automatic ftk_cmd_t rand_offer(input logic signed [31:0] centre);
    ftk_cmd_t c;
    c.command = CMD_OFFER;
    case ($urandom_range(9))
      0:       c.cand_distance = $urandom;
      1:       c.cand_distance = 32'sh7FFF_FFFF;
      2:       c.cand_distance = 32'sh8000_0000;
      default: c.cand_distance = centre + 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
    endcase
    c.cand_finite = ($urandom_range(9) != 0);
    case ($urandom_range(19))
      0:          c.cand_id = EMPTY_ID;
      1:          c.cand_id = EMPTY_ID - 32'd1;
      2, 3, 4, 5: c.cand_id = $urandom;
      default:    c.cand_id = $urandom_range(0, 31);  // small ids make ties likely
    endcase
    c.attr_pass = ($urandom_range(9) != 0);
    c.id_pass   = ($urandom_range(9) != 0);
    return c;
  endfunction

  function automatic logic [31:0] pick_level();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom;
      default: return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
    endcase
  endfunction

  // Half the time, junk in the bits above a narrow register's width.
  function automatic logic [31:0] junk_above(input logic [31:0] v, input int w);
    if ($urandom_range(1) == 0) return v;
    return v | ($urandom << w);
  endfunction

  // One command transfer, after a random idle stretch; start stays high afterwards
  // so that a following item can go out on the very next cycle.
  task automatic send_item(input ftk_cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      if (drv_start) begin
        start     <= 1'b0;
        drv_start  = 1'b0;
      end
      item_i <= rand_offer($urandom);
      @(posedge clk_i);
    end
    start     <= 1'b1;
    drv_start  = 1'b1;
    item_i    <= c;
    do @(posedge clk_i); while (busy);
    n_items++;
    if (c.command == CMD_DRAIN) n_drains++;
  endtask

  task automatic send_and_predict(input ftk_cmd_t c);
    send_item(c);
    topk_predict(c);
    foreach (step_res[i]) pending_res.push_back(step_res[i]);
  endtask

  // Hold the sender off until every owed result has arrived and the block is idle.
  task automatic settle();
    if (drv_start) begin
      start     <= 1'b0;
      drv_start  = 1'b0;
    end
    while (pending_res.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_KEEP_COUNT:       cfg_mirror.keep_count       = data[KEEP_W-1:0];
      CFG_RANGE_MODE:       cfg_mirror.range_mode       = data[0];
      CFG_THRESHOLD_ENABLE: cfg_mirror.threshold_enable = data[0];
      CFG_THRESHOLD_VALUE:  cfg_mirror.threshold_value  = data;
      CFG_RERANK_ENABLE:    cfg_mirror.rerank_enable    = data[0];
      CFG_SEARCH_RADIUS:    cfg_mirror.search_radius    = data;
      CFG_RADIUS_SLACK:     cfg_mirror.radius_slack     = data[15:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Fresh settings for a random phase: phases 0 and 1 of every six pin K to its extremes.
  task automatic pick_settings(input int phase);
    logic [KEEP_W-1:0] kc;
    logic              rm;
    logic [15:0]       slack;
    case (phase % 6)
      0:       kc = KEEP_W'(TOPK_DEPTH);
      1:       kc = KEEP_W'(1);
      default: begin
        case ($urandom_range(5))
          0:       kc = KEEP_W'(0);
          1:       kc = KEEP_W'($urandom_range(TOPK_DEPTH + 1, 31));
          default: kc = KEEP_W'($urandom_range(2, 8));
        endcase
      end
    endcase
    rm = (phase % 4 == 2) ? 1'b1 : 1'($urandom);
    case ($urandom_range(3))
      0:       slack = 16'h0000;
      1:       slack = 16'hFFFF;
      default: slack = 16'($urandom);
    endcase
    settle();
    write_reg(CFG_KEEP_COUNT,       junk_above(32'(kc), KEEP_W));
    write_reg(CFG_RANGE_MODE,       junk_above(32'(rm), 1));
    write_reg(CFG_THRESHOLD_ENABLE, junk_above(32'($urandom_range(1)), 1));
    write_reg(CFG_THRESHOLD_VALUE,  pick_level());
    write_reg(CFG_RERANK_ENABLE,    junk_above(32'($urandom_range(1)), 1));
    write_reg(CFG_SEARCH_RADIUS,    pick_level());
    write_reg(CFG_RADIUS_SLACK,     junk_above(32'(slack), 16));
    if ($urandom_range(3) == 0) write_reg(CFG_SPARE_IDX, $urandom);
    n_settings++;
    // cluster candidates round whatever boundary is live
    if (cfg_mirror.range_mode)            aim = cfg_mirror.search_radius;
    else if (cfg_mirror.threshold_enable) aim = cfg_mirror.threshold_value;
    else                                  aim = 0;
  endtask

  // Table row builders
  function automatic dir_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [31:0] data);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic dir_row_t row_item(input ftk_cmd_t c);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_ITEM;
    r.item = c;
    return r;
  endfunction

  // Single result carrying no entry.
  function automatic dir_row_t row_known(input ftk_cmd_t c, input logic acc,
                                         input int fill);
    dir_row_t r;
    r                 = '0;
    r.kind            = ROW_KNOWN;
    r.item            = c;
    r.want.accepted   = acc;
    r.want.fill_count = FILL_W'(fill);
    r.want.last       = 1'b1;
    return r;
  endfunction

  // Single result: insertion that pushed out one entry.
  function automatic dir_row_t row_evict(input ftk_cmd_t c, input logic [31:0] id,
                                         input logic [31:0] ev_dist, input int fill);
    dir_row_t r;
    r                      = row_known(c, 1'b1, fill);
    r.want.evicted         = 1'b1;
    r.want.entry_valid     = 1'b1;
    r.want.result_id       = id;
    r.want.result_distance = ev_dist;
    return r;
  endfunction

  task automatic build_table();
    // after reset, K = 10, nearest mode, no threshold
    dir_tab.push_back(row_known(drain_cmd(), 1'b0, 0));                      // empty drain
    dir_tab.push_back(row_known(offer(0, EMPTY_ID, 1, 1, 1), 1'b0, 0));      // empty slot id
    dir_tab.push_back(row_known(offer(32'h7FFF_FFFF, 0, 1, 1, 1), 1'b1, 1));
    dir_tab.push_back(row_known(offer(32'h8000_0000, EMPTY_ID - 1, 1, 1, 1), 1'b1, 2));
    dir_tab.push_back(row_known(offer(7, 1, 1, 0, 1), 1'b0, 2));             // attribute filter
    dir_tab.push_back(row_known(offer(7, 2, 1, 1, 0), 1'b0, 2));             // id filter
    dir_tab.push_back(row_known(offer(5, 9, 0, 1, 1), 1'b1, 3));             // not finite, room left
    dir_tab.push_back(row_item(offer(100, 7, 1, 1, 1)));
    dir_tab.push_back(row_item(offer(100, 5, 1, 1, 1)));                     // tie, smaller id
    dir_tab.push_back(row_item(drain_cmd()));
    // K = 1: equal distance does not beat the worst, nor does a non-finite one
    dir_tab.push_back(row_cfg(CFG_KEEP_COUNT, 1));
    dir_tab.push_back(row_known(offer(10, 1, 1, 1, 1), 1'b1, 1));
    dir_tab.push_back(row_known(offer(10, 2, 1, 1, 1), 1'b0, 1));
    dir_tab.push_back(row_known(offer(0, 3, 0, 1, 1), 1'b0, 1));
    dir_tab.push_back(row_evict(offer(3, 4, 1, 1, 1), 1, 10, 1));
    // K = 0 behaves as 1, K = 31 as the full depth
    dir_tab.push_back(row_cfg(CFG_KEEP_COUNT, 0));
    dir_tab.push_back(row_evict(offer(2, 5, 1, 1, 1), 4, 3, 1));
    dir_tab.push_back(row_cfg(CFG_KEEP_COUNT, 31));
    dir_tab.push_back(row_item(offer(50, 6, 1, 1, 1)));
    dir_tab.push_back(row_item(offer(60, 7, 1, 1, 1)));
    // K lowered under the fill: failing candidate trims nothing, passing one
    // goes in uncompared and the trim may throw it straight out again
    dir_tab.push_back(row_cfg(CFG_KEEP_COUNT, 2));
    dir_tab.push_back(row_known(offer(1, 9, 1, 0, 1), 1'b0, 3));
    dir_tab.push_back(row_item(offer(99, 10, 0, 1, 1)));
    dir_tab.push_back(row_item(drain_cmd()));
    // range mode: boundary at radius plus slack, and no wrap at the top
    dir_tab.push_back(row_cfg(CFG_KEEP_COUNT, TOPK_DEPTH));
    dir_tab.push_back(row_cfg(CFG_RANGE_MODE, 1));
    dir_tab.push_back(row_cfg(CFG_SEARCH_RADIUS, 32'h0001_0000));
    dir_tab.push_back(row_cfg(CFG_RADIUS_SLACK, 32'h0000_FFFF));
    dir_tab.push_back(row_item(offer(32'h0001_FFFF, 1, 1, 1, 1)));
    dir_tab.push_back(row_item(offer(32'h0002_0000, 2, 1, 1, 1)));
    dir_tab.push_back(row_item(offer(0, 3, 0, 1, 1)));
    dir_tab.push_back(row_cfg(CFG_SEARCH_RADIUS, 32'h7FFF_FFFF));
    dir_tab.push_back(row_item(offer(32'h7FFF_FFFF, 4, 1, 1, 1)));
    dir_tab.push_back(row_item(drain_cmd()));
    // threshold in nearest mode, then with rerank
    dir_tab.push_back(row_cfg(CFG_RANGE_MODE, 0));
    dir_tab.push_back(row_cfg(CFG_THRESHOLD_ENABLE, 1));
    dir_tab.push_back(row_cfg(CFG_THRESHOLD_VALUE, 0));
    dir_tab.push_back(row_known(offer(0, 1, 1, 1, 1), 1'b1, 1));
    dir_tab.push_back(row_known(offer(1, 2, 1, 1, 1), 1'b0, 1));
    dir_tab.push_back(row_known(offer(-5, 3, 0, 1, 1), 1'b0, 1));
    dir_tab.push_back(row_cfg(CFG_RERANK_ENABLE, 1));
    dir_tab.push_back(row_cfg(CFG_SPARE_IDX, 32'hFFFF_FFFF));
    dir_tab.push_back(row_known(offer(1, 3, 1, 1, 1), 1'b1, 2));
    dir_tab.push_back(row_item(drain_cmd()));
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: the receiver cannot hold results off, so every cycle with
  // res_valid_o high is a transfer and is matched against the oldest owed result.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input ftk_res_t want,
                                 input ftk_res_t got);
    n_errors++;
    if (n_errors <= MAX_REPORTS) begin
      $display("%0t %s", $realtime, what);
      $display("  want acc=%0b ev=%0b vld=%0b id=%h dist=%0d fill=%0d last=%0b",
               want.accepted, want.evicted, want.entry_valid, want.result_id,
               want.result_distance, want.fill_count, want.last);
      $display("  got  acc=%0b ev=%0b vld=%0b id=%h dist=%0d fill=%0d last=%0b",
               got.accepted, got.evicted, got.entry_valid, got.result_id,
               got.result_distance, got.fill_count, got.last);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      n_results++;
      if (res_o.evicted === 1'b1) n_evictions++;
      if (pending_res.size() == 0) begin
        report_mismatch("result with nothing owed", '0, res_o);
      end else begin
        want_res = pending_res.pop_front();
        if (res_o.accepted        !== want_res.accepted        ||
            res_o.evicted         !== want_res.evicted         ||
            res_o.entry_valid     !== want_res.entry_valid     ||
            res_o.result_id       !== want_res.result_id       ||
            res_o.result_distance !== want_res.result_distance ||
            res_o.fill_count      !== want_res.fill_count      ||
            res_o.last            !== want_res.last)
          report_mismatch("result mismatch", want_res, res_o);
      end
    end
  end

  // Watchdog: counts cycles without any command or result transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no transfer for %0d cycles, %0d results owed",
                 $realtime, stall_cycles, pending_res.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    mirror_reset();
    build_table();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, sender never idle
    foreach (dir_tab[i]) begin
      case (dir_tab[i].kind)
        ROW_CFG: begin
          settle();
          write_reg(dir_tab[i].idx, dir_tab[i].data);
        end
        ROW_KNOWN: begin
          send_item(dir_tab[i].item);
          topk_predict(dir_tab[i].item);  // keeps the mirror in step
          pending_res.push_back(dir_tab[i].want);
        end
        default: send_and_predict(dir_tab[i].item);
      endcase
    end

    // random searches: runs of offers then usually a drain; a store left
    // undrained carries into the next phase, where K may have shrunk
    while (n_rand < RAND_ITEMS) begin
      case (ph % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 68;
        default: idle_pct = 20;
      endcase
      pick_settings(ph);
      ph_items = 0;
      while (ph_items < PHASE_ITEMS && n_rand < RAND_ITEMS) begin
        n_off = $urandom_range(1, eff_keep() + 6);
        repeat (n_off) begin
          send_and_predict(rand_offer(aim));
          ph_items++;
          n_rand++;
        end
        if ($urandom_range(7) == 0) settle();  // sender waits for the block to empty
        if ($urandom_range(3) != 0) begin
          send_and_predict(drain_cmd());
          ph_items++;
          n_rand++;
        end
      end
      ph++;
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    n_errors += pending_res.size();

    $display("Covered %0d items (%0d drains), %0d results of which %0d evictions,",
             n_items, n_drains, n_results, n_evictions);
    $display("  across %0d random register settings plus the directed table; %0d errors.",
             n_settings, n_errors);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ftk_pkg.sv
rtl/ftk_gate.sv
rtl/filtered_topk_selector_top.sv
rtl/ftk_checker.sv
tb/sv/filtered_topk_selector_top_test.sv
